### rtl/ofdmnsd_pkg.sv
`timescale 1ns / 1ps

package ofdmnsd_pkg;

  localparam int DELAY_DEPTH    = 128;
  localparam int DELAY_AW       = $clog2(DELAY_DEPTH);
  localparam int SEARCH_TIMEOUT = 2000000;

  localparam int MAG_W    = 16;
  localparam int LEVEL_W  = 19;
  localparam int CNT_W    = 21;
  localparam int FFT_W    = 13;
  localparam int GUARD_W  = 11;
  localparam int SPF_W    = 8;
  localparam int SYM_W    = 14;
  localparam int FLEN_W   = SPF_W + SYM_W;
  localparam int LEAK_SHIFT = 3;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  localparam int OFIFO_DEPTH = 3;
  localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
  localparam int OFIFO_CW    = $clog2(OFIFO_DEPTH + 1);

  localparam logic [LEVEL_W-1:0] LEVEL_INIT = LEVEL_W'(1000);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX  = {LEVEL_W{1'b1}};
  localparam logic [CNT_W-1:0]   COUNT_MAX  = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0]   TIMEOUT    = CNT_W'(SEARCH_TIMEOUT);

  localparam logic [CFG_IDX_W-1:0] CFG_FFT_LENGTH        = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GUARD_LENGTH      = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_PER_FRAME = CFG_IDX_W'(2);

  localparam logic [FFT_W-1:0]   FFT_LENGTH_RST        = FFT_W'(2048);
  localparam logic [GUARD_W-1:0] GUARD_LENGTH_RST      = GUARD_W'(504);
  localparam logic [SPF_W-1:0]   SYMBOLS_PER_FRAME_RST = SPF_W'(76);

  typedef struct packed {
    logic signed [15:0] i_sample;
    logic signed [15:0] q_sample;
  } in_item_t;

  typedef struct packed {
    logic frame_start;
    logic no_signal;
  } out_item_t;

  typedef struct packed {
    logic [FFT_W-1:0]   fft_length;
    logic [GUARD_W-1:0] guard_length;
    logic [SPF_W-1:0]   symbols_per_frame;
  } config_t;

  typedef struct packed {
    logic                we;
    logic [DELAY_AW-1:0] waddr;
    logic [LEVEL_W-1:0]  wdata;
    logic                re;
    logic [DELAY_AW-1:0] raddr;
  } ram_req_t;

endpackage

### rtl/ofdmnsd_ram.sv
`timescale 1ns / 1ps

module ofdmnsd_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 19
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/ofdmnsd_core.sv
`timescale 1ns / 1ps

module ofdmnsd_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  ofdmnsd_pkg::in_item_t          in_data,
  input  logic                           cfg_we,
  input  logic [ofdmnsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ofdmnsd_pkg::CFG_W-1:0]  cfg_data,
  output ofdmnsd_pkg::ram_req_t          ram_req,
  input  logic [ofdmnsd_pkg::LEVEL_W-1:0] ram_rdata,
  output logic                           res_valid,
  output ofdmnsd_pkg::out_item_t         res_data
);

  import ofdmnsd_pkg::*;

  function automatic logic [16:0] abs17(input logic signed [15:0] v);
    logic [16:0] e;
    e = {v[15], v};
    abs17 = v[15] ? (~e + 17'd1) : e;
  endfunction

  config_t              cfg;
  logic [FLEN_W-1:0]    frame_len;
  logic [CNT_W-1:0]     reload;

  logic [DELAY_AW-1:0]  wr_idx;
  logic [DELAY_AW-1:0]  rd_idx;
  logic [DELAY_DEPTH-1:0] ent_vld;

  logic [16:0]          ai;
  logic [16:0]          aq;
  logic [16:0]          hi;
  logic [16:0]          lo;
  logic [MAG_W-1:0]     mag;

  logic                 s1_valid;
  logic [MAG_W-1:0]     s1_mag;
  logic [DELAY_AW-1:0]  s1_waddr;
  logic                 fwd_hit;
  logic [LEVEL_W-1:0]   fwd_data;
  logic                 old_vld;

  logic [LEVEL_W-1:0]   avg;
  logic [LEVEL_W-1:0]   avg_next;
  logic [LEVEL_W:0]     avg_sum;
  logic [LEVEL_W-1:0]   old_level;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     cnt_inc;
  logic [CNT_W-1:0]     cnt_next;
  logic                 start;
  logic                 nosig;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fft_length        <= FFT_LENGTH_RST;
      cfg.guard_length      <= GUARD_LENGTH_RST;
      cfg.symbols_per_frame <= SYMBOLS_PER_FRAME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FFT_LENGTH:        cfg.fft_length        <= cfg_data[FFT_W-1:0];
        CFG_GUARD_LENGTH:      cfg.guard_length      <= cfg_data[GUARD_W-1:0];
        CFG_SYMBOLS_PER_FRAME: cfg.symbols_per_frame <= cfg_data[SPF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    frame_len <= FLEN_W'(cfg.symbols_per_frame) *
                 FLEN_W'(SYM_W'(cfg.fft_length) + SYM_W'(cfg.guard_length));
  end

  assign reload = (frame_len > FLEN_W'(COUNT_MAX)) ? COUNT_MAX : frame_len[CNT_W-1:0];

  // magnitude estimate
  always_comb begin
    ai  = abs17(in_data.i_sample);
    aq  = abs17(in_data.q_sample);
    hi  = (ai > aq) ? ai : aq;
    lo  = (ai > aq) ? aq : ai;
    mag = MAG_W'(hi + {1'b0, lo[16:1]});
  end

  // next entry to be overwritten is the one compared
  assign rd_idx = (wr_idx == DELAY_AW'(DELAY_DEPTH - 1)) ? '0 : wr_idx + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wr_idx   <= '0;
      ent_vld  <= '0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        wr_idx <= rd_idx;
      end
      if (s1_valid) begin
        ent_vld[s1_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mag   <= mag;
      s1_waddr <= wr_idx;
      fwd_hit  <= s1_valid && (s1_waddr == rd_idx);
      fwd_data <= avg_next;
      old_vld  <= ent_vld[rd_idx];
    end
  end

  // level average and counter update
  always_comb begin
    avg_sum   = {1'b0, avg} - (LEVEL_W+1)'(avg >> LEAK_SHIFT) + (LEVEL_W+1)'(s1_mag);
    avg_next  = (avg_sum > (LEVEL_W+1)'(LEVEL_MAX)) ? LEVEL_MAX : avg_sum[LEVEL_W-1:0];
    old_level = fwd_hit ? fwd_data : (old_vld ? ram_rdata : LEVEL_INIT);
    start     = (old_level < LEVEL_W'(s1_mag)) && (FLEN_W'(cnt) > frame_len);
    if (start) begin
      cnt_inc = '0;
    end else if (cnt != COUNT_MAX) begin
      cnt_inc = cnt + 1'b1;
    end else begin
      cnt_inc = cnt;
    end
    nosig    = (cnt_inc >= TIMEOUT);
    cnt_next = nosig ? reload : cnt_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg <= LEVEL_INIT;
      cnt <= '0;
    end else if (s1_valid) begin
      avg <= avg_next;
      cnt <= cnt_next;
    end
  end

  always_comb begin
    ram_req.we    = s1_valid;
    ram_req.waddr = s1_waddr;
    ram_req.wdata = avg_next;
    ram_req.re    = accept;
    ram_req.raddr = rd_idx;
  end

  assign res_valid            = s1_valid;
  assign res_data.frame_start = start;
  assign res_data.no_signal   = nosig;

endmodule

### rtl/ofdmnsd_ofifo.sv
`timescale 1ns / 1ps

module ofdmnsd_ofifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  ofdmnsd_pkg::out_item_t        push_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ofdmnsd_pkg::out_item_t        out_data,
  output logic [ofdmnsd_pkg::OFIFO_CW-1:0] count
);

  import ofdmnsd_pkg::*;

  out_item_t            mem [OFIFO_DEPTH];
  logic [OFIFO_AW-1:0]  wptr;
  logic [OFIFO_AW-1:0]  rptr;
  logic                 pop;

  assign out_valid = (count != '0);
  assign out_data  = mem[rptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == OFIFO_AW'(OFIFO_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == OFIFO_AW'(OFIFO_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/ofdm_null_symbol_frame_detector_unit.sv
// Null-symbol frame start detector for an OFDM baseband stream.
// Input channel in_valid/in_ready carries one complex I/Q sample per
// transaction; output channel out_valid/out_ready returns exactly one
// result (frame_start, no_signal) per sample, in order.
// Configuration: cfg_we with cfg_index 0 = fft_length, 1 = guard_length,
// 2 = symbols_per_frame; other indexes are ignored. Write only while idle.
// Each result passes the stage-1 register and then the output buffer before
// out_valid shows it. Throughput: one sample per cycle while in_ready is high,
// set by the update of the level average and sample counter plus one write
// and one read of the 128-entry level delay RAM per cycle (read-before-write,
// forwarded when the same entry is hit).
// Reset: configuration returns to 2048/504/76, average to 1000, counter to
// 0; per-entry valid flags make every delay entry read as 1000 until it is
// written, so no clearing pass is needed and input is taken right away.
// Receiver stall: results collect in a three-entry buffer; in_ready drops
// when buffered plus in-flight results would fill it, so nothing is lost.
`timescale 1ns / 1ps

module ofdm_null_symbol_frame_detector_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ofdmnsd_pkg::in_item_t             in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ofdmnsd_pkg::out_item_t            out_data,
  input  logic                              cfg_we,
  input  logic [ofdmnsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ofdmnsd_pkg::CFG_W-1:0]     cfg_data
);

  import ofdmnsd_pkg::*;

  logic                 accept;
  ram_req_t             ram_req;
  logic [LEVEL_W-1:0]   ram_rdata;
  logic                 res_valid;
  out_item_t            res_data;
  logic [OFIFO_CW-1:0]  count;

  assign in_ready = ((OFIFO_CW+1)'(count) + (OFIFO_CW+1)'(res_valid))
                    < (OFIFO_CW+1)'(OFIFO_DEPTH);
  assign accept   = in_valid && in_ready;

  ofdmnsd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  ofdmnsd_ram #(
    .DEPTH (DELAY_DEPTH),
    .WIDTH (LEVEL_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  ofdmnsd_ofifo u_ofifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .count     (count)
  );

endmodule

### rtl/ofdmnsd_checker.sv
`timescale 1ns / 1ps

module ofdmnsd_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input ofdmnsd_pkg::in_item_t             in_data,
  input logic                              out_valid,
  input logic                              out_ready,
  input ofdmnsd_pkg::out_item_t            out_data,
  input logic                              cfg_we,
  input logic [ofdmnsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [ofdmnsd_pkg::CFG_W-1:0]     cfg_data
);

  import ofdmnsd_pkg::*;

  logic last_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_start <= 1'b0;
    end else if (out_valid && out_ready) begin
      last_start <= out_data.frame_start;
    end
  end

  // a frame start clears the counter, so the timeout cannot fire with it
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.frame_start && out_data.no_signal))
    else $error("frame_start and no_signal in one transaction");

  // the counter is zero after a frame start, so the next sample cannot be one
  a_no_double_start: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_start) |-> !out_data.frame_start)
    else $error("frame_start on two consecutive transactions");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed or dropped");

endmodule

bind ofdm_null_symbol_frame_detector_unit ofdmnsd_checker u_checker (.*);

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ofdmnsd_pkg::*;

  localparam int LW1 = LEVEL_W + 1;
  localparam int STALL_LIMIT = 4000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int RX_HOLD_AT = 400;
  localparam int TRAFFIC_ITEMS = 320;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  ofdm_null_symbol_frame_detector_unit u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // detector mirror
  logic [FFT_W-1:0] cfg_fft = FFT_LENGTH_RST;
  logic [GUARD_W-1:0] cfg_guard = GUARD_LENGTH_RST;
  logic [SPF_W-1:0] cfg_spf = SYMBOLS_PER_FRAME_RST;
  logic [LEVEL_W-1:0] avg_level;
  logic [LEVEL_W-1:0] level_hist [DELAY_DEPTH];
  logic [DELAY_AW-1:0] hist_ptr;
  logic [CNT_W-1:0] since_start;

  in_item_t sample_queue [$];
  out_item_t flags_expected [$];

  int send_idle_pct = 35;
  int recv_idle_pct = 70;
  int errors = 0;
  int results_seen = 0;
  int rx_hold = 0;
  int stall_cycles = 0;

  logic signed [15:0] dir_i [20] = '{0, 1, 0, -1, 32767, -32768, -32768, 32767, -32768, 0,
                                     -32768, 2, 12345, -6789, 100, 101, -3, 21845, -21846,
                                     32767};
  logic signed [15:0] dir_q [20] = '{0, 0, 1, -1, 32767, -32768, 32767, -32768, 0, -32768,
                                     1, -32768, -6789, 12345, 101, 100, -2, -21846, 21845,
                                     0};

  function automatic out_item_t detect_step(in_item_t s);
    logic [16:0] ai, aq, hi, lo, mag;
    logic [LW1-1:0] nxt;
    logic [FLEN_W-1:0] flen;
    out_item_t r;
    ai = s.i_sample[15] ? 17'h10000 - {1'b0, s.i_sample} : {1'b0, s.i_sample};
    aq = s.q_sample[15] ? 17'h10000 - {1'b0, s.q_sample} : {1'b0, s.q_sample};
    hi = (ai > aq) ? ai : aq;
    lo = (ai > aq) ? aq : ai;
    mag = hi + (lo >> 1);
    flen = FLEN_W'(cfg_spf) * (FLEN_W'(cfg_fft) + FLEN_W'(cfg_guard));
    nxt = LW1'(avg_level) - LW1'(avg_level >> LEAK_SHIFT) + LW1'(mag);
    avg_level = (nxt > LW1'(LEVEL_MAX)) ? LEVEL_MAX : nxt[LEVEL_W-1:0];
    level_hist[hist_ptr] = avg_level;
    hist_ptr = hist_ptr + 1'b1;
    r.frame_start = 1'b0;
    r.no_signal = 1'b0;
    if (LW1'(level_hist[hist_ptr]) < LW1'(mag) && FLEN_W'(since_start) > flen) begin
      r.frame_start = 1'b1;
      since_start = '0;
    end else if (since_start < COUNT_MAX) begin
      since_start = since_start + 1'b1;
    end
    if (since_start >= TIMEOUT) begin
      r.no_signal = 1'b1;
      since_start = (flen > FLEN_W'(COUNT_MAX)) ? COUNT_MAX : flen[CNT_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] quiet_part();
    logic [15:0] m;
    m = 16'($urandom_range(0, 63));
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  function automatic logic signed [15:0] loud_part();
    logic [15:0] m;
    m = 16'($urandom_range(8192, 32767));
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2, 3: return $urandom_range(0, 1) ? -m : m;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic push_sample(input logic signed [15:0] a, input logic signed [15:0] b);
    in_item_t s;
    s.i_sample = a;
    s.q_sample = b;
    sample_queue.push_back(s);
  endtask

  // quiet stretches followed by bursts, with some raw noise mixed in
  task automatic make_traffic(input int n);
    int cnt, len;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 9) < 8) begin
        len = $urandom_range(20, 220);
        if (len > n - cnt) len = n - cnt;
        repeat (len) push_sample(quiet_part(), quiet_part());
        cnt += len;
        len = $urandom_range(1, 24);
        if (len > n - cnt) len = n - cnt;
        repeat (len) push_sample(loud_part(), loud_part());
        cnt += len;
      end else begin
        len = $urandom_range(1, 30);
        if (len > n - cnt) len = n - cnt;
        repeat (len) push_sample(16'($urandom()), 16'($urandom()));
        cnt += len;
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_FFT_LENGTH: cfg_fft = val[FFT_W-1:0];
      CFG_GUARD_LENGTH: cfg_guard = val[GUARD_W-1:0];
      CFG_SYMBOLS_PER_FRAME: cfg_spf = val[SPF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_frame_cfg(input logic [CFG_W-1:0] fft, input logic [CFG_W-1:0] guard,
                               input logic [CFG_W-1:0] spf);
    write_reg(CFG_FFT_LENGTH, fft);
    write_reg(CFG_GUARD_LENGTH, guard);
    write_reg(CFG_SYMBOLS_PER_FRAME, spf);
    write_reg(CFG_UNUSED, CFG_W'($urandom()));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (sample_queue.size() != 0 || in_valid || flags_expected.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin : drive
    in_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        flags_expected.push_back(detect_step(in_data));
      end
      if (!in_valid || in_ready) begin
        if (sample_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = sample_queue.pop_front();
          in_data <= nxt;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (flags_expected.size() == 0) begin
          $display("%0t unexpected transaction: expected none actual %b", $time, out_data);
          errors++;
        end else begin
          want = flags_expected.pop_front();
          if (out_data.frame_start !== want.frame_start) begin
            $display("%0t frame_start mismatch: expected %b actual %b", $time,
                     want.frame_start, out_data.frame_start);
            errors++;
          end
          if (out_data.no_signal !== want.no_signal) begin
            $display("%0t no_signal mismatch: expected %b actual %b", $time,
                     want.no_signal, out_data.no_signal);
            errors++;
          end
        end
        results_seen++;
        if (results_seen == RX_HOLD_AT) rx_hold = RX_HOLD_CYCLES;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t watchdog: no transaction for %0d cycles", $time, stall_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    avg_level = LEVEL_INIT;
    for (int k = 0; k < DELAY_DEPTH; k++) level_hist[k] = LEVEL_INIT;
    hist_ptr = '0;
    since_start = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < 20; k++) push_sample(dir_i[k], dir_q[k]);
    drain();

    set_frame_cfg(1, 0, 1);
    make_traffic(TRAFFIC_ITEMS);
    drain();

    set_frame_cfg(0, 0, 0);
    make_traffic(TRAFFIC_ITEMS);
    drain();

    send_idle_pct = 70;
    recv_idle_pct = 35;
    // out-of-width data: guard and symbol count take their low bits
    set_frame_cfg(13'h1fff, 13'h1fff, 13'h1fff);
    make_traffic(TRAFFIC_ITEMS);
    drain();

    set_frame_cfg(16, 4, 2);
    make_traffic(TRAFFIC_ITEMS);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_frame_cfg(CFG_W'($urandom_range(1, 64)), CFG_W'($urandom_range(0, 16)),
                  CFG_W'($urandom_range(1, 4)));
    make_traffic(TRAFFIC_ITEMS);
    drain();

    set_frame_cfg(4096, 1024, 255);
    make_traffic(TRAFFIC_ITEMS / 2);
    drain();

    set_frame_cfg(1, 1, 1);
    make_traffic(TRAFFIC_ITEMS / 2);
    drain();

    repeat (8) @(posedge clk);
    if (flags_expected.size() != 0) begin
      $display("%0t %0d transactions never arrived", $time, flags_expected.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/ofdmnsd_pkg.sv
rtl/ofdmnsd_ram.sv
rtl/ofdmnsd_core.sv
rtl/ofdmnsd_ofifo.sv
rtl/ofdm_null_symbol_frame_detector_unit.sv
rtl/ofdmnsd_checker.sv
bench/tb_top.sv
